[hw/rtl/pbts_pkg.sv]
// Shared types and constants for the priority bitmap task scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pbts_pkg;

    localparam int TASK_ID_W  = 4;
    localparam int DELAY_W    = 32;
    localparam int TICK_W     = 10;
    localparam int CUR_W      = 5;
    localparam int READY_W    = 16;
    localparam int MODE_W     = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 10'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_DELAY   = 3'd1,
        MODE_SUSPEND = 3'd2,
        MODE_RESUME  = 3'd3,
        MODE_CREATE  = 3'd4,
        MODE_LOCK    = 3'd5,
        MODE_UNLOCK  = 3'd6,
        MODE_START   = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_SCHED,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

[hw/rtl/priority_bitmap_task_scheduler_core.sv]
// Priority bitmap task scheduler core: event sequencer, ready bitmap and scheduling.
//
// Usage:
//   Slave channel carries one event per beat: tuser = mode, tdata = task_id
//   (bits 3:0) then delay_ms (bits 35:4). Master channel returns one result
//   beat per event: current_task, switch_request, accepted, ready_set.
//   i_cfg_we with i_cfg_wdata loads the tick period in ms; write only while idle.
// Flow:
//   tick with system running and unlocked: the result register waits for the
//   walk over the delay memory, one entry read and written back per cycle.
//   Other events go through execute, sometimes scheduling, then output.
//   One event is in flight at a time; the next beat is taken as soon as the
//   result is in the output register.
// Reset:
//   synchronous, active low; all tasks cleared, scheduler unlocked, system
//   not running, tick period 10 ms. Delay entries are marked invalid, so no
//   clearing pass is needed.
// Stall:
//   a held result keeps o_m_tvalid high; the core takes one more event and
//   then waits with its next result until the held beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module priority_bitmap_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [pbts_pkg::TICK_W-1:0]      i_cfg_wdata,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [3:0] task_id, [35:4] delay_ms, [39:36] zero
    input  wire logic [pbts_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [2:0] mode
    input  wire logic [pbts_pkg::MODE_W-1:0]      i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [4:0] current_task, [5] switch_request, [6] accepted, [22:7] ready_set, [23] zero
    output logic      [pbts_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    import pbts_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int RW = $clog2(MAX_TASKS + 1);

    t_state                 r_state, n_state;
    t_mode                  r_mode, n_mode;
    logic [TASK_ID_W-1:0]   r_tid, n_tid;
    logic [DELAY_W-1:0]     r_dly, n_dly;
    logic [MAX_TASKS-1:0]   r_ready, n_ready;
    logic [MAX_TASKS-1:0]   r_susp, n_susp;
    logic [RW-1:0]          r_run, n_run;
    logic                   r_sys, n_sys;
    logic                   r_unl, n_unl;
    logic [TICK_W-1:0]      r_tp;
    logic                   r_sw, n_sw;
    logic                   r_acc, n_acc;
    logic                   r_force, n_force;
    logic [RW-1:0]          r_cnt, n_cnt;
    logic [IW-1:0]          r_widx, n_widx;
    logic                   r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0]   r_m_data, n_m_data;

    logic                   st_we, st_clr;
    logic [IW-1:0]          st_waddr, st_raddr;
    logic [DELAY_W-1:0]     st_wdata, st_rdata;

    logic                   tid_ok, run_ok;
    logic [IW-1:0]          tid_idx, run_idx;
    logic [RW-1:0]          best;
    logic [DELAY_W-1:0]     dec;

    pbts_dly_store #(
        .DEPTH (MAX_TASKS),
        .DW    (DELAY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (st_we),
        .i_clr   (st_clr),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign tid_ok  = 32'(r_tid) < MAX_TASKS;
    assign run_ok  = 32'(r_run) < MAX_TASKS;
    assign tid_idx = IW'(r_tid);
    assign run_idx = IW'(r_run);
    assign dec     = (st_rdata > DELAY_W'(r_tp)) ? (st_rdata - DELAY_W'(r_tp)) : '0;

    always_comb begin
        best = RW'(MAX_TASKS);
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (r_ready[i]) begin
                best = RW'(i);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_tid     = r_tid;
        n_dly     = r_dly;
        n_ready   = r_ready;
        n_susp    = r_susp;
        n_run     = r_run;
        n_sys     = r_sys;
        n_unl     = r_unl;
        n_sw      = r_sw;
        n_acc     = r_acc;
        n_force   = r_force;
        n_cnt     = r_cnt;
        n_widx    = r_widx;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_data  = r_m_data;
        st_we     = 1'b0;
        st_clr    = 1'b0;
        st_waddr  = r_widx;
        st_wdata  = dec;
        st_raddr  = IW'(i_s_tdata[TASK_ID_W-1:0]);
        o_s_tready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_mode  = t_mode'(i_s_tuser);
                    n_tid   = i_s_tdata[TASK_ID_W-1:0];
                    n_dly   = i_s_tdata[TASK_ID_W +: DELAY_W];
                    n_sw    = 1'b0;
                    n_acc   = 1'b1;
                    n_force = 1'b0;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_OUT;
                case (r_mode)
                    MODE_TICK: begin
                        if (r_sys && r_unl) begin
                            n_cnt   = '0;
                            n_state = ST_TICK;
                        end
                    end
                    MODE_DELAY: begin
                        if (r_dly != '0) begin
                            if (run_ok) begin
                                n_ready[run_idx] = 1'b0;
                                st_we    = 1'b1;
                                st_waddr = run_idx;
                                st_wdata = r_dly;
                            end
                            n_state = ST_SCHED;
                        end
                    end
                    MODE_SUSPEND: begin
                        if (tid_ok && r_ready[tid_idx]) begin
                            n_susp[tid_idx]  = 1'b1;
                            n_ready[tid_idx] = 1'b0;
                            if (RW'(tid_idx) == r_run) begin
                                n_state = ST_SCHED;
                            end
                        end else begin
                            n_acc = 1'b0;
                        end
                    end
                    MODE_RESUME: begin
                        if (!tid_ok || r_ready[tid_idx] || !r_susp[tid_idx]) begin
                            n_acc = 1'b0;
                        end else begin
                            n_ready[tid_idx] = 1'b1;
                            n_susp[tid_idx]  = 1'b0;
                            if (st_rdata == '0) begin
                                n_state = ST_SCHED;
                            end
                        end
                    end
                    MODE_CREATE: begin
                        if (tid_ok) begin
                            st_clr           = 1'b1;
                            st_waddr         = tid_idx;
                            n_susp[tid_idx]  = 1'b0;
                            n_ready[tid_idx] = 1'b1;
                        end
                    end
                    MODE_LOCK: begin
                        n_unl = 1'b0;
                    end
                    MODE_UNLOCK: begin
                        n_unl = 1'b1;
                    end
                    MODE_START: begin
                        if (!r_sys) begin
                            st_clr                 = 1'b1;
                            st_waddr               = IW'(MAX_TASKS - 1);
                            n_susp[MAX_TASKS - 1]  = 1'b0;
                            n_ready[MAX_TASKS - 1] = 1'b1;
                            n_sys                  = 1'b1;
                            n_force                = 1'b1;
                            n_state                = ST_SCHED;
                        end
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_TICK: begin
                // write back the entry read last cycle, read the next one
                if (r_cnt != '0 && st_rdata != '0) begin
                    st_we    = 1'b1;
                    st_waddr = r_widx;
                    st_wdata = dec;
                    if (dec == '0 && !r_susp[r_widx]) begin
                        n_ready[r_widx] = 1'b1;
                    end
                end
                if (32'(r_cnt) < MAX_TASKS) begin
                    st_raddr = IW'(r_cnt);
                    n_widx   = IW'(r_cnt);
                    n_cnt    = r_cnt + RW'(1);
                end else begin
                    n_state = ST_SCHED;
                end
            end
            ST_SCHED: begin
                if (r_force || (r_unl && best != r_run)) begin
                    n_run = best;
                    n_sw  = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {1'b0, READY_W'(r_ready), r_acc, r_sw, CUR_W'(r_run)};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ready   <= '0;
            r_susp    <= '0;
            r_run     <= '0;
            r_sys     <= 1'b0;
            r_unl     <= 1'b1;
            r_tp      <= TICK_PERIOD_RST;
            r_sw      <= 1'b0;
            r_acc     <= 1'b1;
            r_force   <= 1'b0;
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_susp    <= n_susp;
            r_run     <= n_run;
            r_sys     <= n_sys;
            r_unl     <= n_unl;
            r_sw      <= n_sw;
            r_acc     <= n_acc;
            r_force   <= n_force;
            r_cnt     <= n_cnt;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_tp <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_tid    <= n_tid;
        r_dly    <= n_dly;
        r_widx   <= n_widx;
        r_m_data <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_ready_not_suspended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_susp) == '0)
        else $error("task both ready and suspended");

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_run) <= MAX_TASKS)
        else $error("current task beyond task count");

    a_accept_starts_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_EXEC))
        else $error("accepted beat did not start execution");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) |-> (32'(r_cnt) <= MAX_TASKS))
        else $error("tick walk counter overran");

endmodule
`default_nettype wire

[hw/rtl/pbts_dly_store.sv]
// Per-task delay counter memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module pbts_dly_store #(
    parameter int DEPTH = 16,
    parameter int DW    = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic          i_clr,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [DW-1:0]    r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end else if (i_clr) begin
                r_vld[i_waddr] <= 1'b0;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    // an entry never written since reset or since task creation reads as zero
    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule
`default_nettype wire
